### src/mbm_pkg.sv
// ----------------------------------------------------------------------------
// mbm_pkg
// Shared types and constants for the Modbus RTU poll/write master.
// ----------------------------------------------------------------------------
`default_nettype none

package mbm_pkg;

    // Frame geometry
    localparam int READ_WORDS      = 40;
    localparam int WRITE_WORDS     = 20;
    localparam int RX_DEPTH        = 2 * READ_WORDS + 5;
    localparam int WRITE_REPLY_LEN = 8;
    localparam int RX_HDR_LEN      = 3;

    localparam int CNT_W     = $clog2(RX_DEPTH + 1);
    localparam int RX_AW     = $clog2(RX_DEPTH);
    localparam int WW_AW     = (WRITE_WORDS > 1) ? $clog2(WRITE_WORDS) : 1;
    localparam int MAX_WORDS = (READ_WORDS > WRITE_WORDS) ? READ_WORDS : WRITE_WORDS;
    localparam int WORD_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int HDR_W     = 3;

    // Modbus CRC-16, reflected polynomial
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Request header byte positions
    localparam logic [HDR_W-1:0] HDR_ADDR     = 3'd0;
    localparam logic [HDR_W-1:0] HDR_FUNC     = 3'd1;
    localparam logic [HDR_W-1:0] HDR_START_HI = 3'd2;
    localparam logic [HDR_W-1:0] HDR_START_LO = 3'd3;
    localparam logic [HDR_W-1:0] HDR_QTY_HI   = 3'd4;
    localparam logic [HDR_W-1:0] HDR_QTY_LO   = 3'd5;
    localparam logic [HDR_W-1:0] HDR_BYTES    = 3'd6;

    localparam logic [HDR_W-1:0] READ_HDR_LAST  = HDR_QTY_LO;
    localparam logic [HDR_W-1:0] WRITE_HDR_LAST = HDR_BYTES;

    // Function codes
    localparam logic [7:0] FC_READ  = 8'h03;
    localparam logic [7:0] FC_WRITE = 8'h10;

    localparam logic [7:0] READ_QTY_HI  = 8'(READ_WORDS >> 8);
    localparam logic [7:0] READ_QTY_LO  = 8'(READ_WORDS);
    localparam logic [7:0] WRITE_QTY_HI = 8'(WRITE_WORDS >> 8);
    localparam logic [7:0] WRITE_QTY_LO = 8'(WRITE_WORDS);
    localparam logic [7:0] READ_BYTES   = 8'(2 * READ_WORDS);
    localparam logic [7:0] WRITE_BYTES  = 8'(2 * WRITE_WORDS);

    // Input actions
    localparam logic [1:0] ACT_POLL  = 2'd0;
    localparam logic [1:0] ACT_LOAD  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;
    localparam logic [1:0] ACT_RX    = 2'd3;

    // Result kinds
    localparam logic [1:0] KIND_TX  = 2'd0;
    localparam logic [1:0] KIND_REG = 2'd1;
    localparam logic [1:0] KIND_ACK = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_STATION     = 2'd0;
    localparam logic [1:0] CFG_READ_START  = 2'd1;
    localparam logic [1:0] CFG_WRITE_START = 2'd2;

    typedef enum logic [2:0] {
        SEL_HDR  = 3'd0,
        SEL_WHI  = 3'd1,
        SEL_WLO  = 3'd2,
        SEL_CRCL = 3'd3,
        SEL_CRCH = 3'd4,
        SEL_REG  = 3'd5,
        SEL_ACK  = 3'd6
    } t_emit_sel;

    typedef struct packed {
        logic              start_read;
        logic              start_write;
        logic              load_word;
        logic              rx_push;
        logic              clr_read;
        logic              clr_write;
        logic              emit;
        logic              last;
        logic              wmem_rd;
        logic              rxmem_rd;
        logic              rx_lo;
        logic              capture_hi;
        t_emit_sel         sel;
        logic [HDR_W-1:0]  hdr_idx;
        logic              is_write;
        logic [WORD_W-1:0] word;
    } t_cmd;

    typedef struct packed {
        logic read_pending;
        logic write_pending;
        logic read_match;
        logic write_match;
        logic slot_free;
    } t_status;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b0000_0000_0001,
        S_HDR   = 12'b0000_0000_0010,
        S_FETCH = 12'b0000_0000_0100,
        S_WHI   = 12'b0000_0000_1000,
        S_WLO   = 12'b0000_0001_0000,
        S_CRCL  = 12'b0000_0010_0000,
        S_CRCH  = 12'b0000_0100_0000,
        S_CHECK = 12'b0000_1000_0000,
        S_RDA   = 12'b0001_0000_0000,
        S_RDB   = 12'b0010_0000_0000,
        S_RDE   = 12'b0100_0000_0000,
        S_ACK   = 12'b1000_0000_0000
    } t_state;

endpackage

`default_nettype wire

### src/modbus_rtu_master_poll_write_unit.sv
// A poll emits 8 bytes at 1 per cycle while the output is not stalled.
// A write emits 49 bytes (each data word: 1 memory read + 2 bytes).
// Each received byte is checked before a new item is taken; a completed read reply
// adds 40 words (two receive-buffer reads per word). A word load stays in idle.
// Reset (i_rst_n low, synchronous) clears flags, counters and config to defaults;
// receive and write-word buffers are not cleared.
// ----------------------------------------------------------------------------
// modbus_rtu_master_poll_write_unit
// Modbus RTU master issuing read-holding polls and write-multiple requests.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_master_poll_write_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_action,
    input  logic [4:0]  i_word_index,
    input  logic [15:0] i_word_value,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic [5:0]  o_reg_index,
    output logic [15:0] o_reg_value,
    output logic        o_last,
    output logic [15:0] o_error_count,
    output logic [15:0] o_ok_count
);
    import mbm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    mbm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    mbm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_cfg_ready   (o_cfg_ready),
        .i_word_index  (i_word_index),
        .i_word_value  (i_word_value),
        .i_rx_byte     (i_rx_byte),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_kind        (o_kind),
        .o_tx_byte     (o_tx_byte),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_last        (o_last),
        .o_error_count (o_error_count),
        .o_ok_count    (o_ok_count)
    );

endmodule

`default_nettype wire

### src/mbm_ctrl.sv
// ----------------------------------------------------------------------------
// mbm_ctrl
// Transaction sequencer: accepts items, walks frame bytes and reply words.
// ----------------------------------------------------------------------------
`default_nettype none

module mbm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [1:0]       i_action,
    output logic             o_ready,
    input  mbm_pkg::t_status i_status,
    output mbm_pkg::t_cmd    o_cmd
);
    import mbm_pkg::*;

    t_state            r_state, n_state;
    logic [HDR_W-1:0]  r_step, n_step;
    logic [WORD_W-1:0] r_word, n_word;
    logic              r_is_write, n_is_write;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_step     <= '0;
            r_word     <= '0;
            r_is_write <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_step     <= n_step;
            r_word     <= n_word;
            r_is_write <= n_is_write;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_step     = r_step;
        n_word     = r_word;
        n_is_write = r_is_write;
        o_ready    = 1'b0;
        o_cmd          = '0;
        o_cmd.sel      = SEL_HDR;
        o_cmd.hdr_idx  = r_step;
        o_cmd.is_write = r_is_write;
        o_cmd.word     = r_word;

        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    case (i_action)
                        ACT_POLL: begin
                            if (!i_status.write_pending) begin
                                o_cmd.start_read = 1'b1;
                                n_is_write = 1'b0;
                                n_step     = '0;
                                n_state    = S_HDR;
                            end
                        end
                        ACT_LOAD: o_cmd.load_word = 1'b1;
                        ACT_WRITE: begin
                            if (!i_status.read_pending) begin
                                o_cmd.start_write = 1'b1;
                                n_is_write = 1'b1;
                                n_step     = '0;
                                n_state    = S_HDR;
                            end
                        end
                        ACT_RX: begin
                            o_cmd.rx_push = 1'b1;
                            n_state = S_CHECK;
                        end
                        default: ;
                    endcase
                end
            end
            S_HDR: begin
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_step = r_step + 1'b1;
                    if (r_step == (r_is_write ? WRITE_HDR_LAST : READ_HDR_LAST)) begin
                        n_word  = '0;
                        n_state = r_is_write ? S_FETCH : S_CRCL;
                    end
                end
            end
            S_FETCH: begin
                o_cmd.wmem_rd = 1'b1;
                n_state = S_WHI;
            end
            S_WHI: begin
                o_cmd.sel = SEL_WHI;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_WLO;
                end
            end
            S_WLO: begin
                o_cmd.sel = SEL_WLO;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_word == WORD_W'(WRITE_WORDS - 1)) begin
                        n_state = S_CRCL;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = S_FETCH;
                    end
                end
            end
            S_CRCL: begin
                o_cmd.sel = SEL_CRCL;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state = S_CRCH;
                end
            end
            S_CRCH: begin
                o_cmd.sel = SEL_CRCH;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_CHECK: begin
                if (i_status.read_match) begin
                    o_cmd.clr_read = 1'b1;
                    n_word  = '0;
                    n_state = S_RDA;
                end else if (i_status.write_match) begin
                    o_cmd.clr_write = 1'b1;
                    n_state = S_ACK;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RDA: begin
                o_cmd.rxmem_rd = 1'b1;
                n_state = S_RDB;
            end
            S_RDB: begin
                // high byte lands now, low byte read goes out
                o_cmd.rxmem_rd   = 1'b1;
                o_cmd.rx_lo      = 1'b1;
                o_cmd.capture_hi = 1'b1;
                n_state = S_RDE;
            end
            S_RDE: begin
                o_cmd.sel = SEL_REG;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    if (r_word == WORD_W'(READ_WORDS - 1)) begin
                        o_cmd.last = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_word  = r_word + 1'b1;
                        n_state = S_RDA;
                    end
                end
            end
            S_ACK: begin
                o_cmd.sel = SEL_ACK;
                if (i_status.slot_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

`default_nettype wire

### src/mbm_dp.sv
// ----------------------------------------------------------------------------
// mbm_dp
// Datapath: config, transaction flags, counters, buffers, CRC, result register.
// ----------------------------------------------------------------------------
`default_nettype none

module mbm_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [1:0]       i_cfg_index,
    input  logic [15:0]      i_cfg_data,
    output logic             o_cfg_ready,
    input  logic [4:0]       i_word_index,
    input  logic [15:0]      i_word_value,
    input  logic [7:0]       i_rx_byte,
    input  mbm_pkg::t_cmd    i_cmd,
    output mbm_pkg::t_status o_status,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_tx_byte,
    output logic [5:0]       o_reg_index,
    output logic [15:0]      o_reg_value,
    output logic             o_last,
    output logic [15:0]      o_error_count,
    output logic [15:0]      o_ok_count
);
    import mbm_pkg::*;

    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [7:0]       r_station;
    logic [15:0]      r_read_start;
    logic [15:0]      r_write_start;
    logic             r_read_pending;
    logic             r_write_pending;
    logic [CNT_W-1:0] r_rx_count;
    logic [CNT_W-1:0] r_expected;
    logic [15:0]      r_err;
    logic [15:0]      r_ok;
    logic [7:0]       r_hdr_addr;
    logic [7:0]       r_hdr_func;
    logic [7:0]       r_hdr_bytes;
    logic [15:0]      r_crc;

    logic [7:0]       r_rx_mem [RX_DEPTH];
    logic [15:0]      r_w_mem  [WRITE_WORDS];
    logic [7:0]       r_rx_rd;
    logic [7:0]       r_rx_hi;
    logic [15:0]      r_wword;

    logic             r_o_valid;
    logic [1:0]       r_kind;
    logic [7:0]       r_tx_byte;
    logic [5:0]       r_reg_index;
    logic [15:0]      r_reg_value;
    logic             r_last;
    logic [15:0]      r_err_out;
    logic [15:0]      r_ok_out;

    logic             w_rx_room;
    logic [RX_AW-1:0] w_rx_rd_addr;
    logic             w_full;
    logic             w_slot_free;
    logic [7:0]       w_hdr_byte;
    logic [1:0]       w_kind;
    logic [7:0]       w_tx_byte;
    logic [5:0]       w_reg_index;
    logic [15:0]      w_reg_value;

    assign o_cfg_ready  = 1'b1;
    assign w_rx_room    = (r_rx_count < CNT_W'(RX_DEPTH));
    assign w_rx_rd_addr = RX_AW'(RX_HDR_LEN) + RX_AW'({i_cmd.word, i_cmd.rx_lo});
    assign w_full       = (r_rx_count >= r_expected) && (r_rx_count >= CNT_W'(RX_HDR_LEN));
    assign w_slot_free  = !r_o_valid || i_ready;

    assign o_status.read_pending  = r_read_pending;
    assign o_status.write_pending = r_write_pending;
    assign o_status.slot_free     = w_slot_free;
    assign o_status.read_match    = r_read_pending && w_full
                                    && (r_hdr_addr == r_station)
                                    && (r_hdr_func == FC_READ)
                                    && (r_hdr_bytes == READ_BYTES)
                                    && (r_rx_count >= CNT_W'(RX_DEPTH));
    assign o_status.write_match   = r_write_pending && !r_read_pending && w_full
                                    && (r_hdr_addr == r_station)
                                    && (r_hdr_func == FC_WRITE);

    // Request header bytes
    always_comb begin
        case (i_cmd.hdr_idx)
            HDR_ADDR:     w_hdr_byte = r_station;
            HDR_FUNC:     w_hdr_byte = i_cmd.is_write ? FC_WRITE : FC_READ;
            HDR_START_HI: w_hdr_byte = i_cmd.is_write ? r_write_start[15:8]
                                                      : r_read_start[15:8];
            HDR_START_LO: w_hdr_byte = i_cmd.is_write ? r_write_start[7:0]
                                                      : r_read_start[7:0];
            HDR_QTY_HI:   w_hdr_byte = i_cmd.is_write ? WRITE_QTY_HI : READ_QTY_HI;
            HDR_QTY_LO:   w_hdr_byte = i_cmd.is_write ? WRITE_QTY_LO : READ_QTY_LO;
            HDR_BYTES:    w_hdr_byte = WRITE_BYTES;
            default:      w_hdr_byte = 8'h00;
        endcase
    end

    always_comb begin
        w_kind      = KIND_TX;
        w_tx_byte   = 8'h00;
        w_reg_index = 6'd0;
        w_reg_value = 16'h0000;
        case (i_cmd.sel)
            SEL_HDR:  w_tx_byte = w_hdr_byte;
            SEL_WHI:  w_tx_byte = r_wword[15:8];
            SEL_WLO:  w_tx_byte = r_wword[7:0];
            SEL_CRCL: w_tx_byte = r_crc[7:0];
            SEL_CRCH: w_tx_byte = r_crc[15:8];
            SEL_REG: begin
                w_kind      = KIND_REG;
                w_reg_index = 6'(i_cmd.word);
                w_reg_value = {r_rx_hi, r_rx_rd};
            end
            SEL_ACK:  w_kind = KIND_ACK;
            default:  w_kind = KIND_TX;
        endcase
    end

    // Control state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station       <= 8'd1;
            r_read_start    <= 16'd0;
            r_write_start   <= 16'd1000;
            r_read_pending  <= 1'b0;
            r_write_pending <= 1'b0;
            r_rx_count      <= '0;
            r_expected      <= CNT_W'(RX_DEPTH);
            r_err           <= 16'd0;
            r_ok            <= 16'd0;
            r_o_valid       <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_STATION:     r_station     <= i_cfg_data[7:0];
                    CFG_READ_START:  r_read_start  <= i_cfg_data;
                    CFG_WRITE_START: r_write_start <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.start_read) begin
                if (r_read_pending) begin
                    r_err <= r_err + 16'd1;
                end
                r_rx_count     <= '0;
                r_read_pending <= 1'b1;
                r_expected     <= CNT_W'(RX_DEPTH);
            end
            if (i_cmd.start_write) begin
                if (r_write_pending) begin
                    r_err <= r_err + 16'd1;
                end
                r_rx_count      <= '0;
                r_write_pending <= 1'b1;
                r_expected      <= CNT_W'(WRITE_REPLY_LEN);
            end
            if (i_cmd.rx_push && w_rx_room) begin
                r_rx_count <= r_rx_count + 1'b1;
            end
            if (i_cmd.clr_read) begin
                r_ok           <= r_ok + 16'd1;
                r_read_pending <= 1'b0;
                r_rx_count     <= '0;
            end
            if (i_cmd.clr_write) begin
                r_write_pending <= 1'b0;
                r_rx_count      <= '0;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_push && w_rx_room) begin
            if (r_rx_count == CNT_W'(0)) begin
                r_hdr_addr <= i_rx_byte;
            end
            if (r_rx_count == CNT_W'(1)) begin
                r_hdr_func <= i_rx_byte;
            end
            if (r_rx_count == CNT_W'(2)) begin
                r_hdr_bytes <= i_rx_byte;
            end
        end
        if (i_cmd.start_read || i_cmd.start_write) begin
            r_crc <= 16'hFFFF;
        end else if (i_cmd.emit && (i_cmd.sel == SEL_HDR || i_cmd.sel == SEL_WHI
                                    || i_cmd.sel == SEL_WLO)) begin
            r_crc <= crc16_byte(r_crc, w_tx_byte);
        end
        if (i_cmd.capture_hi) begin
            r_rx_hi <= r_rx_rd;
        end
        if (i_cmd.emit) begin
            r_kind      <= w_kind;
            r_tx_byte   <= w_tx_byte;
            r_reg_index <= w_reg_index;
            r_reg_value <= w_reg_value;
            r_last      <= i_cmd.last;
            r_err_out   <= r_err;
            r_ok_out    <= r_ok;
        end
    end

    // Receive buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.rx_push && w_rx_room) begin
            r_rx_mem[r_rx_count[RX_AW-1:0]] <= i_rx_byte;
        end
        if (i_cmd.rxmem_rd) begin
            r_rx_rd <= r_rx_mem[w_rx_rd_addr];
        end
    end

    // Local write words
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_word && (i_word_index < 5'(WRITE_WORDS))) begin
            r_w_mem[i_word_index[WW_AW-1:0]] <= i_word_value;
        end
        if (i_cmd.wmem_rd) begin
            r_wword <= r_w_mem[i_cmd.word[WW_AW-1:0]];
        end
    end

    assign o_valid       = r_o_valid;
    assign o_kind        = r_kind;
    assign o_tx_byte     = r_tx_byte;
    assign o_reg_index   = r_reg_index;
    assign o_reg_value   = r_reg_value;
    assign o_last        = r_last;
    assign o_error_count = r_err_out;
    assign o_ok_count    = r_ok_out;

endmodule

`default_nettype wire
